### sv/mpbh_pkg.sv
package mpbh_pkg;

  localparam int DataW = 64;

  typedef enum logic [1:0] {
    StNone    = 2'd0,
    StEnter   = 2'd1,
    StRelease = 2'd2,
    StError   = 2'd3
  } status_e;

  typedef struct packed {
    logic [DataW-1:0] heap_usage;
    logic [DataW-1:0] heap_budget;
    logic             usage_valid;
    logic             last_heap;
    logic [DataW-1:0] pending_upload_bytes;
    logic [DataW-1:0] texture_resident_bytes;
  } in_item_t;

  typedef struct packed {
    status_e          status;
    logic [DataW-1:0] budget_bytes;
    logic             pressure_now;
  } out_item_t;

  // Batch totals including the beat being accepted.
  typedef struct packed {
    logic             failed;
    logic [DataW-1:0] usage;
    logic [DataW-1:0] budget;
  } batch_t;

endpackage

### sv/mpbh_stream_if.sv
interface mpbh_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

### sv/mpbh_accum.sv
module mpbh_accum (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               beat_i,
  input  mpbh_pkg::in_item_t item_i,
  output mpbh_pkg::batch_t   batch_o
);

  localparam int W = mpbh_pkg::DataW;

  logic [W-1:0] usage_q, usage_d;
  logic [W-1:0] budget_q, budget_d;
  logic         failed_q, failed_d;
  logic [W:0]   usage_add, budget_add;
  logic         wrap;

  always_comb begin
    usage_add  = {1'b0, usage_q} + {1'b0, item_i.heap_usage};
    budget_add = {1'b0, budget_q} + {1'b0, item_i.heap_budget};
    // a wrap in either sum drops the whole heap from both sums
    wrap       = usage_add[W] | budget_add[W];

    batch_o.failed = failed_q | wrap | ~item_i.usage_valid;
    batch_o.usage  = wrap ? usage_q : usage_add[W-1:0];
    batch_o.budget = wrap ? budget_q : budget_add[W-1:0];

    if (item_i.last_heap) begin
      usage_d  = '0;
      budget_d = '0;
      failed_d = 1'b0;
    end else begin
      usage_d  = batch_o.usage;
      budget_d = batch_o.budget;
      failed_d = batch_o.failed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      usage_q  <= '0;
      budget_q <= '0;
      failed_q <= 1'b0;
    end else if (beat_i) begin
      usage_q  <= usage_d;
      budget_q <= budget_d;
      failed_q <= failed_d;
    end
  end

endmodule

### sv/memory_pressure_budget_hysteresis_top.sv
// channel | dir | payload               | beat
// --------+-----+-----------------------+-----------------------------
// in_i    | in  | mpbh_pkg::in_item_t   | valid & ready, one heap
// out_o   | out | mpbh_pkg::out_item_t  | valid & ready, one per last_heap
//
// One heap beat per cycle while in_i.ready is high. Heaps only add into the
// running sums; a last_heap beat enters the evaluation pipe and its result
// shows on out_o after the divide-by-five for the 80% figure passes capture,
// a fold stage, a 32-bit reciprocal multiply stage, a subtract stage and the output.
// Pipe stages collapse bubbles; in_i.ready drops only when every stage holds a
// batch and the output beat is stalled.
// Reset clears the sums, the failure flag, the pressure flag and all valids.
module memory_pressure_budget_hysteresis_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  mpbh_stream_if.sink     in_i,
  mpbh_stream_if.source   out_o
);

  localparam int W         = mpbh_pkg::DataW;
  localparam int HalfW     = W / 2;
  localparam int NumStages = 4;   // capture, fold, quotient, target
  // 2^32 is 1 mod 5: b/5 = hi*(2^32-1)/5 + (hi+lo)/5, and the 33-bit sum folds once more
  localparam logic [HalfW-1:0] FoldK     = 32'h3333_3333;  // (2^32 - 1) / 5
  localparam logic [HalfW-1:0] RecipFive = 32'hCCCC_CCCD;  // 2^34 / 5, rounded up

  typedef struct packed {
    logic             failed;
    logic [W-1:0]     usage;
    logic [W-1:0]     budget;
    logic [W-1:0]     pending;
    logic [W-1:0]     tex;
    logic [W-1:0]     hi_quo;
    logic             fold_c;
    logic [HalfW-1:0] fold_t;
    logic [W-1:0]     quo;
    logic [W-1:0]     proj;
    logic [W-1:0]     non_tex;
    logic [W-1:0]     target;
    logic             release_ok;
    logic             enter_ok;
  } rec_t;

  mpbh_pkg::batch_t batch;
  logic             accept;
  logic             last_beat;

  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] vld_in;
  logic [NumStages:0]   rdy;
  rec_t                 p_q     [NumStages];
  rec_t                 stage_d [NumStages];

  logic                  out_vld_q;
  mpbh_pkg::out_item_t   out_q, out_d;
  logic                  pressure_q, pressure_d;
  logic                  fire;

  assign accept    = in_i.valid & rdy[0];
  assign last_beat = accept & in_i.data.last_heap;
  assign in_i.ready = rdy[0];

  mpbh_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .beat_i  (accept),
    .item_i  (in_i.data),
    .batch_o (batch)
  );

  always_comb begin
    rdy[NumStages] = ~out_vld_q | out_o.ready;
    for (int k = NumStages - 1; k >= 0; k--) begin
      rdy[k] = ~vld_q[k] | rdy[k+1];
    end
  end

  assign vld_in = {vld_q[NumStages-2:0], last_beat};

  // Fold stage: projected usage, the release test and the first half of b/5.
  logic [W-1:0]     s1_used, s1_head, s1_proj, s1_non_tex, s1_hi_quo;
  logic [HalfW:0]   s1_fold;
  logic [HalfW-1:0] s1_fold_t;
  logic             s1_release, s1_failed;

  always_comb begin
    s1_used    = (p_q[0].usage < p_q[0].budget) ? p_q[0].usage : p_q[0].budget;
    s1_head    = p_q[0].budget - s1_used;
    s1_proj    = (p_q[0].pending > s1_head) ? p_q[0].budget
                                            : p_q[0].usage + p_q[0].pending;
    s1_non_tex = (p_q[0].usage > p_q[0].tex) ? p_q[0].usage - p_q[0].tex : '0;
    s1_release = p_q[0].usage <= (p_q[0].budget - (p_q[0].budget >> 2));
    s1_failed  = p_q[0].failed | (p_q[0].budget == '0);
    s1_hi_quo  = W'(p_q[0].budget[W-1:HalfW]) * W'(FoldK);
    s1_fold    = {1'b0, p_q[0].budget[W-1:HalfW]} + {1'b0, p_q[0].budget[HalfW-1:0]};
    s1_fold_t  = s1_fold[HalfW-1:0] + HalfW'(s1_fold[HalfW]);
  end

  // Quotient stage: proj >= b - b/10  <=>  proj >= b or 10*(b - proj) <= b.
  logic [W-1:0] s2_gap, s2_recip, s2_quo;
  logic [W+3:0] s2_ten_gap;
  logic         s2_enter;

  always_comb begin
    s2_gap     = p_q[1].budget - p_q[1].proj;
    s2_ten_gap = ((W+4)'(s2_gap) << 3) + ((W+4)'(s2_gap) << 1);
    s2_enter   = (p_q[1].proj >= p_q[1].budget) || (s2_ten_gap <= (W+4)'(p_q[1].budget));
    s2_recip   = W'(p_q[1].fold_t) * W'(RecipFive);
    s2_quo     = p_q[1].hi_quo + (p_q[1].fold_c ? W'(FoldK) : '0)
               + W'(s2_recip[W-1:HalfW+2]);
  end

  always_comb begin
    stage_d[0]            = '0;
    stage_d[0].failed     = batch.failed;
    stage_d[0].usage      = batch.usage;
    stage_d[0].budget     = batch.budget;
    stage_d[0].pending    = in_i.data.pending_upload_bytes;
    stage_d[0].tex        = in_i.data.texture_resident_bytes;

    stage_d[1]            = p_q[0];
    stage_d[1].failed     = s1_failed;
    stage_d[1].proj       = s1_proj;
    stage_d[1].non_tex    = s1_non_tex;
    stage_d[1].release_ok = s1_release;
    stage_d[1].hi_quo     = s1_hi_quo;
    stage_d[1].fold_c     = s1_fold[HalfW];
    stage_d[1].fold_t     = s1_fold_t;

    stage_d[2]            = p_q[1];
    stage_d[2].enter_ok   = s2_enter;
    stage_d[2].quo        = s2_quo;

    stage_d[3]            = p_q[2];
    stage_d[3].target     = p_q[2].budget - p_q[2].quo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumStages; k++) begin
      if (rdy[k] && vld_in[k]) begin
        p_q[k] <= stage_d[k];
      end
    end
  end

  // Result stage: decision against the held pressure flag.
  logic [W:0] bud_diff;

  always_comb begin
    bud_diff   = {1'b0, p_q[NumStages-1].target} - {1'b0, p_q[NumStages-1].non_tex};
    pressure_d = pressure_q;
    out_d.status       = mpbh_pkg::StNone;
    out_d.budget_bytes = '0;
    if (p_q[NumStages-1].failed) begin
      out_d.status = mpbh_pkg::StError;
    end else if (p_q[NumStages-1].enter_ok) begin
      out_d.status       = mpbh_pkg::StEnter;
      out_d.budget_bytes = bud_diff[W] ? '0 : bud_diff[W-1:0];
      pressure_d         = 1'b1;
    end else if (pressure_q && p_q[NumStages-1].release_ok) begin
      out_d.status       = mpbh_pkg::StRelease;
      out_d.budget_bytes = '1;
      pressure_d         = 1'b0;
    end
    out_d.pressure_now = pressure_d;
  end

  assign fire = rdy[NumStages] & vld_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      pressure_q <= 1'b0;
    end else begin
      if (rdy[NumStages]) begin
        out_vld_q <= vld_q[NumStages-1];
      end
      if (fire) begin
        pressure_q <= pressure_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

endmodule

### sv/mpbh_checker.sv
module mpbh_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input mpbh_pkg::out_item_t out_data_i
);

  // pressure flag as last delivered on out
  logic last_p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_p_q <= 1'b0;
    end else if (out_valid_i && out_ready_i) begin
      last_p_q <= out_data_i.pressure_now;
    end
  end

  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("out valid dropped while stalled");

  a_data_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("out payload changed while stalled");

  a_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.status == mpbh_pkg::StNone ||
                    out_data_i.status == mpbh_pkg::StError)
    |-> out_data_i.budget_bytes == '0 && out_data_i.pressure_now == last_p_q)
    else $error("pressure flag or budget moved without enter or release");

  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status == mpbh_pkg::StRelease
    |-> last_p_q && !out_data_i.pressure_now && out_data_i.budget_bytes == '1)
    else $error("release without held pressure or with a limited budget");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status == mpbh_pkg::StEnter |-> out_data_i.pressure_now)
    else $error("enter beat without pressure flag");

endmodule

bind memory_pressure_budget_hysteresis_top mpbh_checker u_mpbh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
